// ----- rtl/mrb_pkg.sv -----
// shared constants, types and saturation helpers of the modal resonator bank
// no dependencies
package mrb_pkg;

   localparam int MAX_MODES    = 256;
   localparam int NUM_CHANNELS = 8;

   localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MODE_W  = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int ADDR_W  = CH_W + MODE_W;
   localparam int CNT_W   = MODE_W + 1;
   localparam int DEPTH   = NUM_CHANNELS * MAX_MODES;

   localparam int ACTION_W  = 1;
   localparam int CHAN_F_W  = 3;
   localparam int MODE_F_W  = 8;
   localparam int COEF_W    = 32;
   localparam int SAMP_W    = 24;
   localparam int DELAY_W   = 40;
   localparam int NMODES_W  = 9;
   localparam int OPA_W     = 25;
   localparam int PROD_W    = OPA_W + COEF_W;
   localparam int Y_W       = 52;
   localparam int ACC_W     = DELAY_W + MODE_W + 1;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 1'b1;

   localparam logic [NMODES_W-1:0] NUM_MODES_RESET = 9'd10;
   localparam logic [0:0] REG_NUM_MODES = 1'b0;

   typedef struct packed {
      logic                     is_load;
      logic [CH_W-1:0]          ch;
      logic [MODE_W-1:0]        mode;
      logic signed [COEF_W-1:0] a0;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [SAMP_W-1:0] x;
   } cmd_type;

   function automatic logic signed [DELAY_W-1:0] sat_delay(
      input logic signed [Y_W-1:0] v);
      logic signed [Y_W-1:0] hi;
      logic signed [Y_W-1:0] lo;
      hi = Y_W'(signed'({1'b0, {(DELAY_W-1){1'b1}}}));
      lo = -hi - Y_W'(1);
      if (v > hi) begin
         return hi[DELAY_W-1:0];
      end else if (v < lo) begin
         return lo[DELAY_W-1:0];
      end
      return v[DELAY_W-1:0];
   endfunction

   function automatic logic signed [SAMP_W-1:0] sat_sample(
      input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(signed'({1'b0, {(SAMP_W-1){1'b1}}}));
      lo = -hi - ACC_W'(1);
      if (v > hi) begin
         return hi[SAMP_W-1:0];
      end else if (v < lo) begin
         return lo[SAMP_W-1:0];
      end
      return v[SAMP_W-1:0];
   endfunction

endpackage

// ----- rtl/mrb_front.sv -----
// front end: takes items, drops out-of-range ones, queues commands for the back end
// depends on mrb_pkg
module mrb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mrb_pkg::ACTION_W-1:0]          req_action,
   input  logic [mrb_pkg::CHAN_F_W-1:0]          req_channel,
   input  logic [mrb_pkg::MODE_F_W-1:0]          req_mode_index,
   input  logic signed [mrb_pkg::COEF_W-1:0]     req_coef_in_a0,
   input  logic signed [mrb_pkg::COEF_W-1:0]     req_coef_in_a1,
   input  logic signed [mrb_pkg::COEF_W-1:0]     req_coef_in_a2,
   input  logic signed [mrb_pkg::SAMP_W-1:0]     req_sample_in,
   output logic                                  cmd_valid,
   output mrb_pkg::cmd_type                      cmd_head,
   input  logic                                  cmd_pop
);
   import mrb_pkg::*;

   cmd_type     q_ff [2];
   cmd_type     new_cmd;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        keep;
   logic        push;
   logic        pop;

   assign req_stall = (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      new_cmd.is_load = (req_action == ACT_LOAD);
      new_cmd.ch      = CH_W'(req_channel);
      new_cmd.mode    = MODE_W'(req_mode_index);
      new_cmd.a0      = req_coef_in_a0;
      new_cmd.a1      = req_coef_in_a1;
      new_cmd.a2      = req_coef_in_a2;
      new_cmd.x       = req_sample_in;
      keep = (int'(req_channel) < NUM_CHANNELS) &&
             (!new_cmd.is_load || (int'(req_mode_index) < MAX_MODES));
   end

   assign push      = accept && keep;
   assign pop       = cmd_pop && (count_ff != 2'd0);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- rtl/mrb_back.sv -----
// back end: coefficient and delay memories, resonator sequencer, result register
// depends on mrb_pkg
module mrb_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   input  mrb_pkg::cmd_type                      cmd_head,
   output logic                                  cmd_pop,
   input  logic [mrb_pkg::NMODES_W-1:0]          num_modes,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mrb_pkg::SAMP_W-1:0]     rsp_sample_out
);
   import mrb_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_WB    = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic signed [COEF_W-1:0]  gain_mem [DEPTH];
   logic signed [COEF_W-1:0]  fb1_mem  [DEPTH];
   logic signed [COEF_W-1:0]  fb2_mem  [DEPTH];
   logic signed [DELAY_W-1:0] d1_mem   [DEPTH];
   logic signed [DELAY_W-1:0] d2_mem   [DEPTH];

   logic [2:0]                state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic [CH_W-1:0]           ch_ff, ch_in;
   logic signed [SAMP_W-1:0]  x_ff, x_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [2:0]                ph_ff, ph_in;
   logic [2:0]                tag_ff, tag_in;
   logic signed [PROD_W-1:0]  p_ff, p_in;
   logic signed [Y_W-1:0]     y_ff, y_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic signed [COEF_W-1:0]  a0_rd, a1_rd, a2_rd;
   logic signed [DELAY_W-1:0] d1_rd, d2_rd;

   logic                      coef_we, delay_we, rd_en;
   logic [ADDR_W-1:0]         wr_addr, rd_addr, cur_addr;
   logic signed [COEF_W-1:0]  wa0, wa1, wa2;
   logic signed [DELAY_W-1:0] wd1, wd2;
   logic signed [OPA_W-1:0]   opa;
   logic signed [COEF_W-1:0]  opb;
   logic signed [Y_W-1:0]     term;
   logic signed [DELAY_W-1:0] ysat;
   logic signed [DELAY_W-1:0] osat;
   logic [CNT_W-1:0]          n_eff;
   logic                      out_free;

   assign cur_addr       = {ch_ff, k_ff[MODE_W-1:0]};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign n_eff = (int'(num_modes) > MAX_MODES) ? CNT_W'(MAX_MODES) : CNT_W'(num_modes);

   always_comb begin
      unique case (ph_ff)
         3'd0: begin
            opa = OPA_W'(x_ff);
            opb = a0_rd;
         end
         3'd1: begin
            opa = OPA_W'(signed'(d1_rd[DELAY_W-1:24]));
            opb = a1_rd;
         end
         3'd2: begin
            opa = signed'({1'b0, d1_rd[23:0]});
            opb = a1_rd;
         end
         3'd3: begin
            opa = OPA_W'(signed'(d2_rd[DELAY_W-1:24]));
            opb = a2_rd;
         end
         3'd4: begin
            opa = signed'({1'b0, d2_rd[23:0]});
            opb = a2_rd;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      unique case (tag_ff)
         3'd0:          term = Y_W'(p_ff >>> 23);
         3'd1, 3'd3:    term = -Y_W'(p_ff);
         3'd2, 3'd4:    term = -Y_W'(p_ff >>> 24);
         default:       term = '0;
      endcase
   end

   assign ysat = sat_delay(y_ff);
   assign osat = sat_delay(Y_W'(ysat) - Y_W'(d2_rd));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ch_in        = ch_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      ph_in        = ph_ff;
      tag_in       = tag_ff;
      p_in         = p_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      coef_we      = 1'b0;
      delay_we     = 1'b0;
      rd_en        = 1'b0;
      wr_addr      = cur_addr;
      rd_addr      = cur_addr;
      wa0          = cmd_head.a0;
      wa1          = cmd_head.a1;
      wa2          = cmd_head.a2;
      wd1          = ysat;
      wd2          = d1_rd;
      unique case (state_ff)
         ST_CLEAR: begin
            coef_we  = 1'b1;
            delay_we = 1'b1;
            wr_addr  = clr_ff;
            wa0      = '0;
            wa1      = '0;
            wa2      = '0;
            wd1      = '0;
            wd2      = '0;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_head.is_load) begin
                  coef_we = 1'b1;
                  wr_addr = {cmd_head.ch, cmd_head.mode};
               end else begin
                  ch_in  = cmd_head.ch;
                  x_in   = cmd_head.x;
                  n_in   = n_eff;
                  k_in   = '0;
                  acc_in = '0;
                  state_in = (n_eff == '0) ? ST_DONE : ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            y_in     = '0;
            ph_in    = 3'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (ph_ff != 3'd5) begin
               p_in   = opa * opb;
               tag_in = ph_ff;
            end
            if (ph_ff != 3'd0) begin
               y_in = y_ff + term;
            end
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd5) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            delay_we = 1'b1;
            acc_in   = acc_ff + ACC_W'(osat);
            k_in     = k_ff + CNT_W'(1);
            state_in = (k_ff + CNT_W'(1) == n_ff) ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_sample(acc_ff >>> 1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      x_ff        <= x_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      ph_ff       <= ph_in;
      tag_ff      <= tag_in;
      p_ff        <= p_in;
      y_ff        <= y_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         gain_mem[wr_addr] <= wa0;
         fb1_mem[wr_addr]  <= wa1;
         fb2_mem[wr_addr]  <= wa2;
      end
      if (delay_we) begin
         d1_mem[wr_addr] <= wd1;
         d2_mem[wr_addr] <= wd2;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         a0_rd <= gain_mem[rd_addr];
         a1_rd <= fb1_mem[rd_addr];
         a2_rd <= fb2_mem[rd_addr];
         d1_rd <= d1_mem[rd_addr];
         d2_rd <= d2_mem[rd_addr];
      end
   end

endmodule

// ----- rtl/modal_resonator_bank.sv -----
// top level of the modal resonator bank: control register, front end, back end
// depends on mrb_pkg, mrb_front, mrb_back
// a load is queued in the front end and written to the coefficient memories by the idle back end;
// a sample's result is registered once every resonator is done; the back end works on one sample
// at a time (read, 5 products, final add and writeback per resonator), loads one per cycle when idle
// reset: after reset the back end zeroes all 2048 memory entries before work
module modal_resonator_bank (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mrb_pkg::ACTION_W-1:0]          req_action,
   input  logic [mrb_pkg::CHAN_F_W-1:0]          req_channel,
   input  logic [mrb_pkg::MODE_F_W-1:0]          req_mode_index,
   input  logic signed [mrb_pkg::COEF_W-1:0]     req_coef_in_a0,
   input  logic signed [mrb_pkg::COEF_W-1:0]     req_coef_in_a1,
   input  logic signed [mrb_pkg::COEF_W-1:0]     req_coef_in_a2,
   input  logic signed [mrb_pkg::SAMP_W-1:0]     req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [mrb_pkg::SAMP_W-1:0]     rsp_sample_out,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [mrb_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [mrb_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [mrb_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import mrb_pkg::*;

   logic [NMODES_W-1:0] num_modes_ff, num_modes_in;
   logic                cmd_valid;
   cmd_type             cmd_head;
   logic                cmd_pop;
   logic                csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_NUM_MODES);
   assign num_modes_in = csr_write ? pwdata[NMODES_W-1:0] : num_modes_ff;
   assign prdata = (paddr[2] == REG_NUM_MODES) ?
                   CSR_DATA_W'(num_modes_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_modes_ff <= NUM_MODES_RESET;
      end else begin
         num_modes_ff <= num_modes_in;
      end
   end

   mrb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_channel    (req_channel),
      .req_mode_index (req_mode_index),
      .req_coef_in_a0 (req_coef_in_a0),
      .req_coef_in_a1 (req_coef_in_a1),
      .req_coef_in_a2 (req_coef_in_a2),
      .req_sample_in  (req_sample_in),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop)
   );

   mrb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop),
      .num_modes      (num_modes_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule

// ----- test/tb_top.sv -----
// self-checking testbench of modal_resonator_bank: a fixed-point model of the resonator bank
// predicts each output sample, and a monitor compares the results as they are accepted
// depends on mrb_pkg and modal_resonator_bank
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import mrb_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 600;
   localparam int SETTLE_CYCLES  = 16;
   localparam logic [CSR_ADDR_W-1:0] ADDR_NUM_MODES = CSR_ADDR_W'(4 * REG_NUM_MODES);

   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic [CHAN_F_W-1:0]      channel;
      logic [MODE_F_W-1:0]      mode_index;
      logic signed [COEF_W-1:0] a0;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [SAMP_W-1:0] sample;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ACTION_W-1:0] req_action = ACT_LOAD;
   logic [CHAN_F_W-1:0] req_channel = '0;
   logic [MODE_F_W-1:0] req_mode_index = '0;
   logic signed [COEF_W-1:0] req_coef_in_a0 = '0;
   logic signed [COEF_W-1:0] req_coef_in_a1 = '0;
   logic signed [COEF_W-1:0] req_coef_in_a2 = '0;
   logic signed [SAMP_W-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SAMP_W-1:0] rsp_sample_out;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   modal_resonator_bank dut (.*);

   // bank model state
   int unsigned active_modes = 10;
   int gain_coef [DEPTH];
   int fb1_coef [DEPTH];
   int fb2_coef [DEPTH];
   longint delay_one [DEPTH];
   longint delay_two [DEPTH];
   logic signed [SAMP_W-1:0] pending_out [$];

   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_on = 1'b0;
   event hold_go;
   int quiet_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint mul_q24(longint d, longint a);
      longint hi;
      longint lo;
      hi = d >>> 24;
      lo = d & 64'hFF_FFFF;
      return hi * a + ((lo * a) >>> 24);
   endfunction

   function automatic logic signed [SAMP_W-1:0] resonate(int unsigned ch, longint x);
      longint acc;
      longint y;
      longint d1;
      longint d2;
      int unsigned n;
      int unsigned idx;
      acc = 0;
      n = active_modes > MAX_MODES ? MAX_MODES : active_modes;
      for (int unsigned k = 0; k < n; k++) begin
         idx = ch * MAX_MODES + k;
         d1 = delay_one[idx];
         d2 = delay_two[idx];
         y = ((x * longint'(gain_coef[idx])) >>> 23) - mul_q24(d1, fb1_coef[idx])
             - mul_q24(d2, fb2_coef[idx]);
         y = clamp(y, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
         acc += clamp(y - d2, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
         delay_two[idx] = d1;
         delay_one[idx] = y;
      end
      acc = clamp(acc >>> 1, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
      return acc[SAMP_W-1:0];
   endfunction

   function automatic void apply_item(req_item_type it);
      int unsigned idx;
      if (it.channel >= NUM_CHANNELS) return;
      if (it.action == ACT_LOAD) begin
         if (it.mode_index >= MAX_MODES) return;
         idx = it.channel * MAX_MODES + it.mode_index;
         gain_coef[idx] = it.a0;
         fb1_coef[idx] = it.a1;
         fb2_coef[idx] = it.a2;
      end else begin
         pending_out.push_back(resonate(it.channel, longint'(it.sample)));
      end
   endfunction

   task automatic report(string what, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      errors++;
   endtask

   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= it.action;
      req_channel <= it.channel;
      req_mode_index <= it.mode_index;
      req_coef_in_a0 <= it.a0;
      req_coef_in_a1 <= it.a1;
      req_coef_in_a2 <= it.a2;
      req_sample_in <= it.sample;
      do @(posedge clock); while (req_stall);
      apply_item(it);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_num_modes(int unsigned value);
      wait_drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_NUM_MODES;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      active_modes = value & 32'h1FF;
      @(posedge clock);
   endtask

   function automatic logic signed [COEF_W-1:0] pick_coef();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1 << 25) - (1 << 24);
         default: return $urandom_range(1 << 22) - (1 << 21);
      endcase
   endfunction

   function automatic req_item_type make_item(logic [ACTION_W-1:0] act, int unsigned ch,
                                              int unsigned mi);
      req_item_type it;
      it.action = act;
      it.channel = CHAN_F_W'(ch);
      it.mode_index = MODE_F_W'(mi);
      it.a0 = pick_coef();
      it.a1 = pick_coef();
      it.a2 = pick_coef();
      it.sample = SAMP_W'($urandom);
      return it;
   endfunction

   function automatic req_item_type fixed_item(logic [ACTION_W-1:0] act, int unsigned ch,
                                               int unsigned mi, int a0, int a1, int a2, int x);
      req_item_type it;
      it.action = act;
      it.channel = CHAN_F_W'(ch);
      it.mode_index = MODE_F_W'(mi);
      it.a0 = a0;
      it.a1 = a1;
      it.a2 = a2;
      it.sample = SAMP_W'(x);
      return it;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_out.size() == 0) begin
            report("unexpected sample_out", 0, rsp_sample_out);
         end else begin
            if (rsp_sample_out !== pending_out[0]) begin
               report("sample_out", pending_out[0], rsp_sample_out);
            end
            void'(pending_out.pop_front());
         end
      end
   end

   // receiver stall
   always @(posedge clock) begin
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
   end

   initial begin
      forever begin
         @(hold_go);
         hold_on = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on = 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(fixed_item(ACT_LOAD, 0, 0, 1 << 24, 0, 0, 0));
      send_item(fixed_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 24'sh7FFFFF));
      send_item(fixed_item(ACT_SAMPLE, 0, 0, 0, 0, 0, -24'sh800000));
      send_item(fixed_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0));
      send_item(fixed_item(ACT_LOAD, 7, 9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
      send_item(fixed_item(ACT_LOAD, 7, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      send_item(fixed_item(ACT_LOAD, 7, 255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      repeat (3) send_item(fixed_item(ACT_SAMPLE, 7, 255, 0, 0, 0, 24'sh7FFFFF));
      repeat (2) send_item(fixed_item(ACT_SAMPLE, 7, 0, 0, 0, 0, -24'sh800000));
      // a load between samples must not clear the delays
      send_item(fixed_item(ACT_LOAD, 7, 9, 1 << 20, -(1 << 24), 1 << 23, 0));
      send_item(fixed_item(ACT_SAMPLE, 7, 0, 0, 0, 0, 24'sh123456));
      write_num_modes(0);
      send_item(fixed_item(ACT_SAMPLE, 7, 0, 0, 0, 0, 24'sh7FFFFF));
      write_num_modes(511);
      send_item(fixed_item(ACT_SAMPLE, 7, 0, 0, 0, 0, 24'sh400000));
      write_num_modes(256);
      send_item(fixed_item(ACT_SAMPLE, 0, 0, 0, 0, 0, -24'sh000001));
      write_num_modes(1);
      send_item(fixed_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 24'sh000001));
      wait_drain();
   endtask

   task automatic test_random(int items, int idle, int stall);
      int sent;
      int unsigned ch;
      int unsigned n;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < items) begin
         write_num_modes($urandom_range(1, 8));
         repeat (4) begin
            n = active_modes;
            ch = $urandom_range(NUM_CHANNELS - 1);
            if ($urandom_range(3) != 0) begin
               repeat ($urandom_range(1, n)) begin
                  send_item(make_item(ACT_LOAD, ch, $urandom_range(n - 1)));
                  sent++;
               end
               repeat ($urandom_range(4, 16)) begin
                  send_item(make_item(ACT_SAMPLE, ch, $urandom_range(255)));
                  sent++;
               end
            end else begin
               repeat ($urandom_range(4, 12)) begin
                  send_item(make_item(ACTION_W'($urandom_range(1)), $urandom_range(7),
                                      $urandom_range(255)));
                  sent++;
               end
            end
         end
      end
      wait_drain();
   endtask

   task automatic test_large_bank();
      send_idle_pct = 10;
      stall_pct = 10;
      write_num_modes(256);
      repeat (4) send_item(make_item(ACT_LOAD, 3, $urandom_range(255)));
      repeat (3) send_item(make_item(ACT_SAMPLE, 3, 0));
      write_num_modes(511);
      repeat (2) send_item(make_item(ACT_SAMPLE, 3, 0));
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      write_num_modes(1);
      -> hold_go;
      repeat (40) send_item(make_item(ACTION_W'($urandom_range(1)), $urandom_range(7), 0));
      wait_drain();
      repeat (10) send_item(make_item(ACT_SAMPLE, $urandom_range(7), 0));
      wait_drain();
      repeat (10) send_item(make_item(ACT_SAMPLE, $urandom_range(7), 0));
      wait_drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450, 0, 0);
      test_random(450, 64, 0);
      test_random(450, 0, 64);
      test_random(450, 30, 30);
      test_large_bank();
      test_backpressure();
      wait_drain();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mrb_pkg.sv
rtl/mrb_front.sv
rtl/mrb_back.sv
rtl/modal_resonator_bank.sv
test/tb_top.sv
